// ----- rtl/sapm_pkg.sv -----
`default_nettype none

package sapm_pkg;

  // first-order low-pass: y = prev + ((FILTER_GAIN * (x - prev)) >>> FILTER_SHIFT)
  localparam int FILTER_GAIN  = 20;
  localparam int FILTER_SHIFT = 8;

  // register reset values
  localparam int  ZERO_OFFSET_RESET    = 2048;
  localparam logic LOWPASS_ENABLE_RESET = 1'b1;
  localparam logic REPORT_ENABLE_RESET  = 1'b0;

  // register indexes on the configuration port
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ZERO_OFFSET    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LOWPASS_ENABLE = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_REPORT_ENABLE  = 2'd2;

  // per-result flags from the tracker
  typedef struct packed {
    logic delay_valid;
    logic amplitude_valid;
    logic report_due;
  } flags_t;

endpackage

`default_nettype wire

// ----- rtl/sapm_cfg.sv -----
`default_nettype none

module sapm_cfg #(
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_write_enable,
  input  wire logic [sapm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [SAMPLE_BITS-1:0]               cfg_data,
  output logic      [SAMPLE_BITS-1:0]               zero_offset,
  output logic                                      lowpass_enable,
  output logic                                      report_enable
);

  localparam logic [SAMPLE_BITS-1:0] OFFSET_RESET =
    SAMPLE_BITS'(sapm_pkg::ZERO_OFFSET_RESET);

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_offset    <= OFFSET_RESET;
      lowpass_enable <= sapm_pkg::LOWPASS_ENABLE_RESET;
      report_enable  <= sapm_pkg::REPORT_ENABLE_RESET;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        sapm_pkg::CFG_ZERO_OFFSET:    zero_offset    <= cfg_data;
        sapm_pkg::CFG_LOWPASS_ENABLE: lowpass_enable <= cfg_data[0];
        sapm_pkg::CFG_REPORT_ENABLE:  report_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sapm_filter.sv -----
`default_nettype none

module sapm_filter #(
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic        [SAMPLE_BITS-1:0] sample,
  input  wire logic        [SAMPLE_BITS-1:0] zero_offset,
  input  wire logic                          lowpass_enable,
  input  wire logic signed [SAMPLE_BITS:0]   prev_value,
  output logic      signed [SAMPLE_BITS:0]   value
);

  localparam int DW = SAMPLE_BITS + 2;
  localparam int PW = SAMPLE_BITS + 7;
  localparam logic signed [PW-1:0] GAIN = PW'(sapm_pkg::FILTER_GAIN);

  logic signed [SAMPLE_BITS:0] centred;
  logic signed [DW-1:0]        diff;
  logic signed [PW-1:0]        product;
  logic signed [PW-1:0]        step_wide;
  logic signed [DW-1:0]        smoothed;

  always_comb begin
    centred   = $signed({1'b0, sample}) - $signed({1'b0, zero_offset});
    diff      = $signed({centred[SAMPLE_BITS], centred})
              - $signed({prev_value[SAMPLE_BITS], prev_value});
    product   = $signed({{(PW-DW){diff[DW-1]}}, diff}) * GAIN;
    // arithmetic shift gives the floor
    step_wide = product >>> sapm_pkg::FILTER_SHIFT;
    smoothed  = $signed({prev_value[SAMPLE_BITS], prev_value}) + step_wide[DW-1:0];
    value     = lowpass_enable ? smoothed[SAMPLE_BITS:0] : centred;
  end

endmodule

`default_nettype wire

// ----- rtl/sapm_track.sv -----
`default_nettype none

module sapm_track #(
  parameter int REPORT_DIVIDE = 10,
  parameter int SAMPLE_BITS   = 12
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          update,
  input  wire logic                          operation,
  input  wire logic signed [SAMPLE_BITS:0]   value,
  input  wire logic        [31:0]            timestamp_ms,
  input  wire logic                          report_enable,
  output logic      signed [SAMPLE_BITS:0]   prev_value,
  output logic      signed [SAMPLE_BITS:0]   filtered_value,
  output logic             [31:0]            delay_ms,
  output logic             [SAMPLE_BITS:0]   amplitude,
  output sapm_pkg::flags_t                   flags
);

  localparam int PKW = SAMPLE_BITS + 2;
  localparam int CW  = $clog2(REPORT_DIVIDE + 1);
  localparam logic [CW-1:0] DIVIDE = CW'(REPORT_DIVIDE);
  localparam logic signed [PKW-1:0] PEAK_MIN_RESET = PKW'(1) <<< SAMPLE_BITS;

  logic signed [PKW-1:0] peak_max;
  logic signed [PKW-1:0] peak_min;
  logic        [31:0]    reference_time;
  logic        [CW-1:0]  report_count;

  logic signed [PKW-1:0] peak_max_next;
  logic signed [PKW-1:0] peak_min_next;
  logic        [CW-1:0]  report_count_next;
  logic signed [PKW-1:0] value_ext;
  logic signed [PKW:0]   span;
  logic        [CW-1:0]  count_up;
  logic                  rising;

  always_comb begin
    value_ext         = $signed({value[SAMPLE_BITS], value});
    span              = $signed({peak_max[PKW-1], peak_max})
                      - $signed({peak_min[PKW-1], peak_min});
    rising            = (prev_value <= 0) && (value > 0);
    count_up          = (report_count < DIVIDE) ? report_count + CW'(1) : report_count;
    peak_max_next     = peak_max;
    peak_min_next     = peak_min;
    report_count_next = report_count;
    filtered_value    = prev_value;
    delay_ms          = '0;
    amplitude         = '0;
    flags             = '0;
    if (operation) begin
      // reference crossing: report amplitude and restart peak tracking
      if (peak_max >= peak_min) begin
        amplitude = span[SAMPLE_BITS+1:1];
      end
      flags.amplitude_valid = 1'b1;
      peak_max_next         = '0;
      peak_min_next         = PEAK_MIN_RESET;
    end else begin
      filtered_value = value;
      if (value_ext > peak_max) begin
        peak_max_next = value_ext;
      end
      if (value_ext < peak_min) begin
        peak_min_next = value_ext;
      end
      if (rising) begin
        delay_ms          = timestamp_ms - reference_time;
        flags.delay_valid = 1'b1;
      end
      report_count_next = count_up;
      if (count_up == DIVIDE && report_enable) begin
        flags.report_due  = 1'b1;
        report_count_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_value     <= '0;
      peak_max       <= '0;
      peak_min       <= PEAK_MIN_RESET;
      reference_time <= '0;
      report_count   <= '0;
    end else if (update) begin
      peak_max     <= peak_max_next;
      peak_min     <= peak_min_next;
      report_count <= report_count_next;
      if (operation) begin
        reference_time <= timestamp_ms;
      end else begin
        prev_value <= value;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sine_amplitude_phase_meter.sv -----
`default_nettype none

// an accepted input transaction passes through the input register, then the result
//   register; throughput: one transaction per cycle while out_stall does not hold the
//   result register, set by the single tracker update per item
// reset (rst, synchronous, active high) clears the pipeline valids, the tracker state
//   (peaks, reference time, previous value, decimation count) and loads register defaults

module sine_amplitude_phase_meter #(
  parameter int REPORT_DIVIDE = 10,
  parameter int SAMPLE_BITS   = 12
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // configuration
  input  wire logic                                 cfg_write_enable,
  input  wire logic [sapm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [SAMPLE_BITS-1:0]               cfg_data,
  // input channel
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 operation,
  input  wire logic [SAMPLE_BITS-1:0]               sample,
  input  wire logic [31:0]                          timestamp_ms,
  // result channel
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [SAMPLE_BITS:0]               filtered_value,
  output logic [31:0]                               delay_ms,
  output logic                                      delay_valid,
  output logic [SAMPLE_BITS:0]                      amplitude,
  output logic                                      amplitude_valid,
  output logic                                      report_due
);

  // configuration registers
  logic [SAMPLE_BITS-1:0] zero_offset;
  logic                   lowpass_enable;
  logic                   report_enable;

  // input register
  logic                   s1_valid;
  logic                   s1_operation;
  logic [SAMPLE_BITS-1:0] s1_sample;
  logic [31:0]            s1_timestamp;

  // between filter and tracker
  logic signed [SAMPLE_BITS:0] prev_value;
  logic signed [SAMPLE_BITS:0] value;

  // tracker results ahead of the result register
  logic signed [SAMPLE_BITS:0] res_value;
  logic [31:0]                 res_delay;
  logic [SAMPLE_BITS:0]        res_amplitude;
  sapm_pkg::flags_t            res_flags;

  logic in_take;
  logic advance;

  // the held item moves on when the result register is empty or being emptied
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  sapm_cfg #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_cfg (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .zero_offset      (zero_offset),
    .lowpass_enable   (lowpass_enable),
    .report_enable    (report_enable)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // payload capture needs no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_operation <= operation;
      s1_sample    <= sample;
      s1_timestamp <= timestamp_ms;
    end
  end

  // offset correction and optional low-pass
  sapm_filter #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_filter (
    .sample         (s1_sample),
    .zero_offset    (zero_offset),
    .lowpass_enable (lowpass_enable),
    .prev_value     (prev_value),
    .value          (value)
  );

  // peaks, crossing delay, amplitude and decimation; state moves only on advance
  sapm_track #(
    .REPORT_DIVIDE (REPORT_DIVIDE),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_track (
    .clk            (clk),
    .rst            (rst),
    .update         (advance),
    .operation      (s1_operation),
    .value          (value),
    .timestamp_ms   (s1_timestamp),
    .report_enable  (report_enable),
    .prev_value     (prev_value),
    .filtered_value (res_value),
    .delay_ms       (res_delay),
    .amplitude      (res_amplitude),
    .flags          (res_flags)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      filtered_value  <= res_value;
      delay_ms        <= res_delay;
      delay_valid     <= res_flags.delay_valid;
      amplitude       <= res_amplitude;
      amplitude_valid <= res_flags.amplitude_valid;
      report_due      <= res_flags.report_due;
    end
  end

endmodule

`default_nettype wire
